// ----- sv/periodic_event_scheduler_core_defines.svh -----
// Assertion macros for the periodic event scheduler
`ifndef PERIODIC_EVENT_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_EVENT_SCHEDULER_CORE_DEFINES_SVH

// a implies b at the same edge
`define PES_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b at the next edge
`define PES_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- sv/pes_pkg.sv -----
// ----------------------------------------------------------------------------
// pes_pkg
// Types and codes shared by the periodic event scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package pes_pkg;
    localparam int unsigned IdW   = 31;
    localparam int unsigned DueW  = 48;
    localparam int unsigned StatW = 3;
    localparam logic [DueW-1:0] DueMax = {DueW{1'b1}};

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SERVE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [StatW-1:0] {
        ST_ADDED   = 3'd0,
        ST_SERVED  = 3'd1,
        ST_CLEARED = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WB,
        S_OUT
    } state_t;

    // candidate record for the minimum search
    typedef struct packed {
        logic [DueW-1:0] due;
        logic [IdW-1:0]  id;
    } cand_t;

    function automatic logic better(cand_t a, cand_t b);
        better = (a.due < b.due) || ((a.due == b.due) && (a.id < b.id));
    endfunction

    function automatic logic [DueW-1:0] sat_add(logic [DueW-1:0] d, logic [IdW-1:0] p);
        logic [DueW:0] s;
        s = {1'b0, d} + {{(DueW+1-IdW){1'b0}}, p};
        sat_add = s[DueW] ? DueMax : s[DueW-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- sv/pes_table.sv -----
// ----------------------------------------------------------------------------
// pes_table
// Subscriber table: one synchronous memory, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none
module pes_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [pes_pkg::DueW-1:0]  wdue,
    input  wire logic [pes_pkg::IdW-1:0]   wper,
    input  wire logic [pes_pkg::IdW-1:0]   wid,
    input  wire logic [AW-1:0]             raddr,
    output logic      [pes_pkg::DueW-1:0]  rdue,
    output logic      [pes_pkg::IdW-1:0]   rper,
    output logic      [pes_pkg::IdW-1:0]   rid
);
    localparam int unsigned W = pes_pkg::DueW + 2 * pes_pkg::IdW;
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wdue, wper, wid};
        end
        rdata_reg <= mem[raddr];
    end

    assign {rdue, rper, rid} = rdata_reg;
endmodule
`default_nettype wire

// ----- sv/periodic_event_scheduler_core.sv -----
// Add, clear, nop and empty serve: the request passes to S_OUT, then the result is registered.
// Serve: scans the table one entry a cycle through its single read port,
// then passes through S_LAST, S_WB and S_OUT. One item at a time; the next
// item is taken once the result register is free.
// Reset (async, rst_n low) empties the table; memory contents are not cleared.
`default_nettype none
module periodic_event_scheduler_core #(
    parameter int unsigned MAX_SUBSCRIBERS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                req_type,
    input  wire logic [pes_pkg::IdW-1:0]   user_id,
    input  wire logic [pes_pkg::IdW-1:0]   period,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic      [pes_pkg::StatW-1:0] status,
    output logic      [pes_pkg::IdW-1:0]   served_id,
    output logic      [pes_pkg::DueW-1:0]  served_time
);
    localparam int unsigned AW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
    localparam int unsigned CW = $clog2(MAX_SUBSCRIBERS + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_SUBSCRIBERS);

    pes_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          found_reg, found_next;
    pes_pkg::cand_t best_reg, best_next;
    logic [pes_pkg::IdW-1:0] bper_reg, bper_next;
    logic [AW-1:0] baddr_reg, baddr_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic [AW-1:0] daddr_reg, daddr_next;
    logic          dv_reg, dv_next;
    logic          out_valid_reg, out_valid_next;
    logic [pes_pkg::StatW-1:0] status_reg, status_next;
    logic [pes_pkg::IdW-1:0]   sid_reg, sid_next;
    logic [pes_pkg::DueW-1:0]  stime_reg, stime_next;

    logic we;
    logic [AW-1:0] waddr;
    logic [pes_pkg::DueW-1:0] wdue, rdue;
    logic [pes_pkg::IdW-1:0]  wper, wid, rper, rid;
    logic accept;
    pes_pkg::cand_t cur;

    pes_table #(.DEPTH(MAX_SUBSCRIBERS), .AW(AW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdue(wdue), .wper(wper), .wid(wid),
        .raddr(raddr_reg), .rdue(rdue), .rper(rper), .rid(rid)
    );

    assign in_stall  = (state_reg != pes_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign served_id   = sid_reg;
    assign served_time = stime_reg;
    assign cur = '{due: rdue, id: rid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pes_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        bper_reg   <= bper_next;
        baddr_reg  <= baddr_next;
        raddr_reg  <= raddr_next;
        daddr_reg  <= daddr_next;
        dv_reg     <= dv_next;
        status_reg <= status_next;
        sid_reg    <= sid_next;
        stime_reg  <= stime_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bper_next      = bper_reg;
        baddr_next     = baddr_reg;
        raddr_next     = raddr_reg;
        daddr_next     = daddr_reg;
        dv_next        = dv_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        sid_next       = sid_reg;
        stime_next     = stime_reg;
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdue  = {{(pes_pkg::DueW-pes_pkg::IdW){1'b0}}, period};
        wper  = period;
        wid   = user_id;
        unique case (state_reg)
            pes_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = pes_pkg::S_OUT;
                    sid_next    = '0;
                    stime_next  = '0;
                    status_next = pes_pkg::ST_EMPTY;
                    unique case (pes_pkg::req_t'(req_type))
                        pes_pkg::REQ_ADD:
                        begin
                            if (count_reg >= CntMax)
                            begin
                                status_next = pes_pkg::ST_FULL;
                            end
                            else
                            begin
                                we          = 1'b1;
                                count_next  = count_reg + CW'(1);
                                status_next = pes_pkg::ST_ADDED;
                            end
                        end
                        pes_pkg::REQ_SERVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = pes_pkg::S_SCAN;
                                raddr_next = '0;
                                ptr_next   = CW'(1);
                                found_next = 1'b0;
                                dv_next    = 1'b0;
                            end
                        end
                        pes_pkg::REQ_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = pes_pkg::ST_CLEARED;
                        end
                        default:
                        begin
                            status_next = pes_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            pes_pkg::S_SCAN:
            begin
                // read data trails raddr_reg by the rdata_reg register; none yet on the first scan cycle
                if (dv_reg && (!found_reg || pes_pkg::better(cur, best_reg)))
                begin
                    found_next = 1'b1;
                    best_next  = cur;
                    bper_next  = rper;
                    baddr_next = daddr_reg;
                end
                daddr_next = raddr_reg;
                dv_next    = 1'b1;
                if (ptr_reg == count_reg)
                begin
                    state_next = pes_pkg::S_LAST;
                end
                else
                begin
                    raddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg + CW'(1);
                end
            end
            pes_pkg::S_LAST:
            begin
                if (!found_reg || pes_pkg::better(cur, best_reg))
                begin
                    found_next = 1'b1;
                    best_next  = cur;
                    bper_next  = rper;
                    baddr_next = daddr_reg;
                end
                state_next = pes_pkg::S_WB;
            end
            pes_pkg::S_WB:
            begin
                we          = 1'b1;
                waddr       = baddr_reg;
                wdue        = pes_pkg::sat_add(best_reg.due, bper_reg);
                wper        = bper_reg;
                wid         = best_reg.id;
                status_next = pes_pkg::ST_SERVED;
                sid_next    = best_reg.id;
                stime_next  = best_reg.due;
                state_next  = pes_pkg::S_OUT;
            end
            pes_pkg::S_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    state_next     = pes_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pes_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/pes_checker.sv -----
// ----------------------------------------------------------------------------
// pes_sva
// Port-level checks on the periodic event scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_event_scheduler_core_defines.svh"
module pes_sva (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [pes_pkg::StatW-1:0] status,
    input wire logic [pes_pkg::IdW-1:0]   served_id,
    input wire logic [pes_pkg::DueW-1:0]  served_time
);
    `PES_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
    `PES_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid,
        status <= pes_pkg::StatW'(pes_pkg::ST_EMPTY))
    `PES_ASSERT_IMPL(a_zero_unless_served, clk, rst_n,
        out_valid && status != pes_pkg::StatW'(pes_pkg::ST_SERVED),
        served_id == '0 && served_time == '0)
    `PES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status))
endmodule

bind periodic_event_scheduler_core pes_sva u_pes_sva (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .served_id(served_id), .served_time(served_time)
);
`default_nettype wire
